// ----- sv/quadrature_pi_position_controller_defines.svh -----
// Assertion helpers for the position controller.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef QUADRATURE_PI_POSITION_CONTROLLER_DEFINES_SVH
`define QUADRATURE_PI_POSITION_CONTROLLER_DEFINES_SVH

// Same-cycle implication.
`define QPIPC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define QPIPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/qpipc_pkg.sv -----
package qpipc_pkg;

	localparam int COUNT_W     = 32;
	localparam int SUM_W       = 40;
	localparam int DRIVE_LIMIT = 1023;

	localparam int GAIN_W    = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int POS_W     = 32;
	localparam int DRIVE_W   = 11;
	localparam int DUTY_W    = 10;

	// Each product term saturates to +-2^TERM_EXP.
	localparam int TERM_EXP   = 41;
	localparam int TERM_W     = TERM_EXP + 2;
	localparam int TOTAL_W    = TERM_W + 1;
	localparam int FRAC_SHIFT = 24;

	localparam int ERR_W  = COUNT_W + 1;
	localparam int ACC_W  = ((SUM_W > ERR_W) ? SUM_W : ERR_W) + 1;
	localparam int OP_W0  = (ERR_W > SUM_W) ? ERR_W : SUM_W;
	localparam int OP_W   = (OP_W0 > TOTAL_W) ? OP_W0 : TOTAL_W;
	localparam int KOP_W  = GAIN_W + 1;
	localparam int PROD_W = OP_W + KOP_W;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic [CFG_W-1:0] TARGET_STEP_RST = 16'd1188;
	localparam logic [CFG_W-1:0] PROP_GAIN_RST   = 16'd768;
	localparam logic [CFG_W-1:0] INTEG_GAIN_RST  = 16'd128;
	localparam logic [CFG_W-1:0] SCALE_RST       = 16'd4976;

	typedef enum logic [1:0] {
		REQ_EDGE = 2'd0,
		REQ_UP   = 2'd1,
		REQ_DOWN = 2'd2,
		REQ_TICK = 2'd3
	} req_type_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TARGET_STEP = 2'd0,
		CFG_PROP_GAIN   = 2'd1,
		CFG_INTEG_GAIN  = 2'd2,
		CFG_SCALE       = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		OP_INC,
		OP_DEC,
		OP_UP,
		OP_DOWN,
		OP_TICK
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROP,
		ST_INTEG,
		ST_ADD,
		ST_SCALE,
		ST_DONE
	} back_state_t;

	typedef struct packed {
		op_t op;
	} entry_t;

	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

endpackage

// ----- sv/qpipc_if.sv -----
interface qpipc_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic       enc_a;
	logic       enc_b;

	modport source(output valid, output req_type, output enc_a, output enc_b, input ready);
	modport sink(input valid, input req_type, input enc_a, input enc_b, output ready);
endinterface

interface qpipc_res_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [qpipc_pkg::DRIVE_W-1:0] drive;
	logic        [qpipc_pkg::DUTY_W-1:0]  duty;
	logic                                 dir_fwd;
	logic                                 dir_rev;
	logic signed [qpipc_pkg::POS_W-1:0]   position;
	logic signed [qpipc_pkg::POS_W-1:0]   target;

	modport source(output valid, output drive, output duty, output dir_fwd, output dir_rev,
		output position, output target, input ready);
	modport sink(input valid, input drive, input duty, input dir_fwd, input dir_rev,
		input position, input target, output ready);
endinterface

// ----- sv/qpipc_front.sv -----
module qpipc_front (
	input  logic              clk,
	input  logic              arst_n,
	qpipc_req_if.sink         req,
	input  qpipc_pkg::qstat_t qstat,
	output logic              push,
	output qpipc_pkg::entry_t push_entry
);

	logic last_a_q;

	assign req.ready = !qstat.full;
	assign push      = req.valid && req.ready;

	// The quadrature direction is resolved here, so the back end sees a plain
	// increment or decrement.
	always_comb begin
		unique case (req.req_type)
			qpipc_pkg::REQ_EDGE: begin
				if ((req.enc_a == last_a_q) != (req.enc_b == req.enc_a))
					push_entry.op = qpipc_pkg::OP_INC;
				else
					push_entry.op = qpipc_pkg::OP_DEC;
			end
			qpipc_pkg::REQ_UP:   push_entry.op = qpipc_pkg::OP_UP;
			qpipc_pkg::REQ_DOWN: push_entry.op = qpipc_pkg::OP_DOWN;
			default:             push_entry.op = qpipc_pkg::OP_TICK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_a_q <= 1'b0;
		end else if (push && req.req_type == qpipc_pkg::REQ_EDGE) begin
			last_a_q <= req.enc_a;
		end
	end

endmodule

// ----- sv/qpipc_fifo.sv -----
module qpipc_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  qpipc_pkg::entry_t push_entry,
	input  logic              pop,
	output qpipc_pkg::entry_t pop_entry,
	output qpipc_pkg::qstat_t qstat
);

	localparam int AW = qpipc_pkg::FIFO_AW;

	qpipc_pkg::entry_t mem_q [qpipc_pkg::FIFO_DEPTH];
	logic [AW-1:0]     wr_ptr_q;
	logic [AW-1:0]     rd_ptr_q;
	logic [AW:0]       level_q;

	assign pop_entry   = mem_q[rd_ptr_q];
	assign qstat.empty = (level_q == '0);
	assign qstat.full  = (level_q == (AW+1)'(qpipc_pkg::FIFO_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

// ----- sv/qpipc_back.sv -----
module qpipc_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [qpipc_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [qpipc_pkg::CFG_W-1:0]          cfg_data,
	input  qpipc_pkg::qstat_t                    qstat,
	input  qpipc_pkg::entry_t                    pop_entry,
	output logic                                 pop,
	qpipc_res_if.source                          res
);

	localparam int CW     = qpipc_pkg::COUNT_W;
	localparam int SW     = qpipc_pkg::SUM_W;
	localparam int EW     = qpipc_pkg::ERR_W;
	localparam int AW     = qpipc_pkg::ACC_W;
	localparam int OW     = qpipc_pkg::OP_W;
	localparam int KW     = qpipc_pkg::KOP_W;
	localparam int PW     = qpipc_pkg::PROD_W;
	localparam int TW     = qpipc_pkg::TERM_W;
	localparam int TOTW   = qpipc_pkg::TOTAL_W;

	localparam logic signed [CW+1:0] CNT_MAX = (CW+2)'((64'sd1 <<< (CW - 1)) - 64'sd1);
	localparam logic signed [CW+1:0] CNT_MIN = -CNT_MAX - 1;
	localparam logic signed [AW-1:0] SUM_MAX = AW'((64'sd1 <<< (SW - 1)) - 64'sd1);
	localparam logic signed [AW-1:0] SUM_MIN = -SUM_MAX - 1;
	localparam logic signed [PW-1:0] TERM_HI = PW'(64'sd1 <<< qpipc_pkg::TERM_EXP);
	localparam logic signed [PW-1:0] TERM_LO = -TERM_HI;
	localparam logic signed [PW-1:0] DRV_HI  = PW'(qpipc_pkg::DRIVE_LIMIT);
	localparam logic signed [PW-1:0] DRV_LO  = -DRV_HI;

	function automatic logic signed [TW-1:0] sat_term(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] r;
		if (p > TERM_HI)
			r = TERM_HI;
		else if (p < TERM_LO)
			r = TERM_LO;
		else
			r = p;
		return TW'(r);
	endfunction

	logic [qpipc_pkg::CFG_W-1:0] step_q, kp_q, ki_q, scale_q;

	qpipc_pkg::back_state_t state_q, state_d;

	logic signed [CW-1:0]   pos_q, tgt_q;
	logic signed [SW-1:0]   sum_q;
	logic signed [EW-1:0]   err_q;
	logic signed [TW-1:0]   term_q;
	logic signed [TOTW-1:0] total_q;
	logic signed [PW-1:0]   prod_q;

	logic signed [CW+1:0] step_x, cnt_in, cnt_delta, cnt_sum;
	logic signed [CW-1:0] cnt_sat;
	logic signed [EW-1:0] err_x;
	logic signed [AW-1:0] acc;
	logic signed [SW-1:0] sum_sat;
	logic signed [OW-1:0] mul_a;
	logic signed [KW-1:0] mul_b;
	logic signed [PW-1:0] shifted, drv_full;
	logic                 mul_en, ld_out, is_tick;

	logic                                 out_valid_q;
	logic signed [qpipc_pkg::DRIVE_W-1:0] drive_q;
	logic        [qpipc_pkg::DUTY_W-1:0]  duty_q;
	logic                                 fwd_q, rev_q;
	logic signed [qpipc_pkg::POS_W-1:0]   pos_out_q, tgt_out_q;

	// Configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= qpipc_pkg::TARGET_STEP_RST;
			kp_q    <= qpipc_pkg::PROP_GAIN_RST;
			ki_q    <= qpipc_pkg::INTEG_GAIN_RST;
			scale_q <= qpipc_pkg::SCALE_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				qpipc_pkg::CFG_TARGET_STEP: step_q  <= cfg_data;
				qpipc_pkg::CFG_PROP_GAIN:   kp_q    <= cfg_data;
				qpipc_pkg::CFG_INTEG_GAIN:  ki_q    <= cfg_data;
				qpipc_pkg::CFG_SCALE:       scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// One saturating adder serves both the position and the target count.
	always_comb begin
		step_x    = signed'((CW+2)'(step_q));
		cnt_in    = (CW+2)'(tgt_q);
		cnt_delta = step_x;
		case (pop_entry.op)
			qpipc_pkg::OP_INC: begin
				cnt_in    = (CW+2)'(pos_q);
				cnt_delta = (CW+2)'(1);
			end
			qpipc_pkg::OP_DEC: begin
				cnt_in    = (CW+2)'(pos_q);
				cnt_delta = -(CW+2)'(1);
			end
			qpipc_pkg::OP_DOWN: cnt_delta = -step_x;
			default: ;
		endcase
		cnt_sum = cnt_in + cnt_delta;
		if (cnt_sum > CNT_MAX)
			cnt_sat = CW'(CNT_MAX);
		else if (cnt_sum < CNT_MIN)
			cnt_sat = CW'(CNT_MIN);
		else
			cnt_sat = CW'(cnt_sum);
	end

	always_comb begin
		err_x = EW'(tgt_q) - EW'(pos_q);
		acc   = AW'(sum_q) + AW'(err_q);
		if (acc > SUM_MAX)
			sum_sat = SW'(SUM_MAX);
		else if (acc < SUM_MIN)
			sum_sat = SW'(SUM_MIN);
		else
			sum_sat = SW'(acc);
	end

	// Shared multiplier operand selection.
	always_comb begin
		case (state_q)
			qpipc_pkg::ST_PROP: begin
				mul_a = OW'(err_q);
				mul_b = signed'(KW'(kp_q));
			end
			qpipc_pkg::ST_INTEG: begin
				mul_a = OW'(sum_q);
				mul_b = signed'(KW'(ki_q));
			end
			default: begin
				mul_a = OW'(total_q);
				mul_b = signed'(KW'(scale_q));
			end
		endcase
	end

	// Floor division by 2^FRAC_SHIFT, then the drive clamp.
	always_comb begin
		shifted = prod_q >>> qpipc_pkg::FRAC_SHIFT;
		if (shifted > DRV_HI)
			drv_full = DRV_HI;
		else if (shifted < DRV_LO)
			drv_full = DRV_LO;
		else
			drv_full = shifted;
	end

	assign is_tick = (pop_entry.op == qpipc_pkg::OP_TICK);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			qpipc_pkg::ST_IDLE: begin
				if (!qstat.empty && is_tick)
					state_d = qpipc_pkg::ST_PROP;
			end
			qpipc_pkg::ST_PROP:  state_d = qpipc_pkg::ST_INTEG;
			qpipc_pkg::ST_INTEG: state_d = qpipc_pkg::ST_ADD;
			qpipc_pkg::ST_ADD:   state_d = qpipc_pkg::ST_SCALE;
			qpipc_pkg::ST_SCALE: state_d = qpipc_pkg::ST_DONE;
			qpipc_pkg::ST_DONE: begin
				if (!out_valid_q || res.ready)
					state_d = qpipc_pkg::ST_IDLE;
			end
			default: state_d = qpipc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		pop    = 1'b0;
		mul_en = 1'b0;
		ld_out = 1'b0;
		unique case (state_q)
			qpipc_pkg::ST_IDLE:  pop    = !qstat.empty;
			qpipc_pkg::ST_PROP:  mul_en = 1'b1;
			qpipc_pkg::ST_INTEG: mul_en = 1'b1;
			qpipc_pkg::ST_SCALE: mul_en = 1'b1;
			qpipc_pkg::ST_DONE:  ld_out = !out_valid_q || res.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qpipc_pkg::ST_IDLE;
			pos_q   <= '0;
			tgt_q   <= '0;
			sum_q   <= '0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				case (pop_entry.op)
					qpipc_pkg::OP_INC, qpipc_pkg::OP_DEC: pos_q <= cnt_sat;
					qpipc_pkg::OP_UP, qpipc_pkg::OP_DOWN: tgt_q <= cnt_sat;
					default: ;
				endcase
			end
			if (state_q == qpipc_pkg::ST_PROP) begin
				sum_q <= sum_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && is_tick) begin
			err_q <= err_x;
		end
		if (mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		if (state_q == qpipc_pkg::ST_INTEG) begin
			term_q <= sat_term(prod_q);
		end
		if (state_q == qpipc_pkg::ST_ADD) begin
			total_q <= TOTW'(term_q) + TOTW'(sat_term(prod_q));
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_out) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			drive_q   <= qpipc_pkg::DRIVE_W'(drv_full);
			duty_q    <= qpipc_pkg::DUTY_W'((drv_full < 0) ? -drv_full : drv_full);
			fwd_q     <= (drv_full > 0);
			rev_q     <= (drv_full < 0);
			pos_out_q <= qpipc_pkg::POS_W'(pos_q);
			tgt_out_q <= qpipc_pkg::POS_W'(tgt_q);
		end
	end

	assign res.valid    = out_valid_q;
	assign res.drive    = drive_q;
	assign res.duty     = duty_q;
	assign res.dir_fwd  = fwd_q;
	assign res.dir_rev  = rev_q;
	assign res.position = pos_out_q;
	assign res.target   = tgt_out_q;

endmodule

// ----- sv/quadrature_pi_position_controller.sv -----
// Quadrature encoder position counter with a PI drive loop.
// Requests enter on req (valid/ready): an encoder edge sample, a target step up,
// a target step down, or a control tick. Only a control tick produces a result
// on res (valid/ready): the clamped drive, its duty magnitude, direction bits,
// and the position and target counts as they stood at the tick.
// Gains, the target step and the drive scale are written through cfg_we/cfg_idx/cfg_data;
// the user must write them only while the block is idle, as the block does not enforce this.
// A four-entry queue sits between the request decoder and the execution unit.
// An edge sample or step command is applied in the execution unit's idle state, which is then
// ready for the next request; a tick passes through the PROP, INTEG, ADD, SCALE and DONE states,
// since one shared multiplier forms kp*err, ki*sum and the final scale product in turn.
// When the receiver stalls, the result waits in the output register; the
// execution unit keeps going until the next tick's result, and requests keep
// being taken until the queue fills.
// Reset clears position, target, integral and the last A level, and loads the
// default configuration; the queue and output register come up empty.
`include "quadrature_pi_position_controller_defines.svh"

module quadrature_pi_position_controller (
	input  logic                              clk,
	input  logic                              arst_n,
	qpipc_req_if.sink                         req,
	qpipc_res_if.source                       res,
	input  logic                              cfg_we,
	input  logic [qpipc_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [qpipc_pkg::CFG_W-1:0]       cfg_data
);

	logic              push, pop;
	qpipc_pkg::entry_t push_entry, pop_entry;
	qpipc_pkg::qstat_t qstat;

	qpipc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.qstat      (qstat),
		.push       (push),
		.push_entry (push_entry)
	);

	qpipc_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.qstat      (qstat)
	);

	qpipc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.qstat     (qstat),
		.pop_entry (pop_entry),
		.pop       (pop),
		.res       (res)
	);

	`QPIPC_ASSERT_IMP(a_full_blocks_req, qstat.full, !req.ready, "request taken into a full queue")
	`QPIPC_ASSERT_IMP(a_pop_nonempty, pop, !qstat.empty, "pop from an empty queue")
	`QPIPC_ASSERT_NEXT(a_tick_holds_queue, pop && pop_entry.op == qpipc_pkg::OP_TICK, !pop, "pop during a tick computation")
	`QPIPC_ASSERT_IMP(a_result_consistent, res.valid, (res.dir_fwd == (res.drive > 0)) && (res.dir_rev == (res.drive < 0)) && !(res.dir_fwd && res.dir_rev), "direction bits disagree with drive")

endmodule
